/* design/svm_pkg.sv */
package svm_pkg;

  localparam logic [15:0] UNITY_Q15 = 16'h8000;
  localparam logic signed [15:0] MIX_MAX = 16'sh7FFF;
  localparam logic signed [15:0] MIX_MIN = 16'sh8000;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_START = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef struct packed {
    logic clear;
    logic valid;
  } mac_ctl_t;

endpackage

/* design/svm_boost.sv */
module svm_boost import svm_pkg::*; (
  input  logic        clk,
  input  logic [15:0] volume,
  output logic [15:0] boost
);

  logic [15:0] inv;
  logic [31:0] sq_full;
  logic [15:0] vol1;
  logic [15:0] inv1;
  logic [30:0] sq1;
  logic [46:0] cube;

  assign inv     = UNITY_Q15 - volume;
  assign sq_full = {16'd0, inv} * {16'd0, inv};
  assign cube    = {16'd0, sq1} * {31'd0, inv1};

  always_ff @(posedge clk) begin
    vol1 <= volume;
    inv1 <= inv;
    sq1  <= sq_full[30:0];
    if (vol1[15]) begin
      boost <= vol1;
    end else begin
      boost <= UNITY_Q15 - cube[45:30];
    end
  end

endmodule

/* design/svm_mac.sv */
module svm_mac import svm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  mac_ctl_t           ctl,
  input  logic signed [15:0] sample,
  input  logic [31:0]        combined,
  output logic signed [15:0] acc
);

  logic [15:0]        mag;
  logic [47:0]        prod_full;
  logic [47:0]        prod;
  logic               neg;
  logic               valid3;
  logic [17:0]        term;
  logic signed [19:0] acc_ext;
  logic signed [19:0] term_ext;
  logic signed [19:0] sum;

  assign mag       = sample[15] ? 16'(-sample) : sample;
  assign prod_full = {32'd0, mag} * {16'd0, combined};
  assign term      = prod[47:30];
  assign acc_ext   = {{4{acc[15]}}, acc};
  assign term_ext  = {2'b00, term};
  assign sum       = neg ? acc_ext - term_ext : acc_ext + term_ext;

  always_ff @(posedge clk) begin
    prod <= prod_full;
    neg  <= sample[15];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid3 <= 1'b0;
      acc    <= '0;
    end else begin
      valid3 <= ctl.valid;
      if (ctl.clear) begin
        acc <= '0;
      end else if (valid3) begin
        priority if (sum > 20'sd32767) begin
          acc <= MIX_MAX;
        end else if (sum < -20'sd32768) begin
          acc <= MIX_MIN;
        end else begin
          acc <= sum[15:0];
        end
      end
    end
  end

endmodule

/* design/saturating_voice_mixer.sv */
// Channel   Direction  Handshake               Payload
// command   in         start, busy             mode, address, sample_value, length, gain
// result    out        done                    mixed_sample, voices_live, start_dropped
// volume    in         cfg_write               cfg_data
//
// A load, a start or an unused mode gives its result in the cycle after the transfer.
// A tick first waits for the volume curve, then reads the sample memory once per voice slot
// in order, then drains the multiply and clamp pipeline, and then gives its result.
// The voice memory has one read and one write port; one slot is read each cycle while a tick scans.
// Reset clears all voices and sets the volume to unity; the sample memory is not cleared.
// Results cannot be stalled; done is high for one cycle. SAMPLE_DEPTH is a power of two.
module saturating_voice_mixer import svm_pkg::*; #(
  parameter int VOICES       = 16,
  parameter int SAMPLE_DEPTH = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode,
  input  logic [15:0]        address,
  input  logic signed [15:0] sample_value,
  input  logic [16:0]        length,
  input  logic [15:0]        gain,
  input  logic               cfg_write,
  input  logic [15:0]        cfg_data,
  output logic               done,
  output logic signed [15:0] mixed_sample,
  output logic               voices_live,
  output logic               start_dropped
);

  localparam int AW = $clog2(SAMPLE_DEPTH);
  localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int XW = (AW > 18) ? AW : 18;

  typedef struct packed {
    logic [15:0] start_addr;
    logic [16:0] len;
    logic [16:0] pos;
    logic [15:0] gain;
  } voice_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BOOST,
    S_SCAN,
    S_DRAIN
  } state_t;

  voice_t             vmem [VOICES];
  logic [15:0]        smem [SAMPLE_DEPTH];

  state_t             state;
  logic [1:0]         cnt;
  logic [IW-1:0]      k;
  logic [VOICES-1:0]  voice_active;
  logic [15:0]        system_volume;
  logic [15:0]        boost;
  logic               any_hold;
  logic               v1_valid;
  logic [IW-1:0]      v1_idx;
  voice_t             vm_rdata;
  logic               v2_valid;
  logic [31:0]        comb2;
  logic [15:0]        sm_rdata;
  logic signed [15:0] acc;
  mac_ctl_t           mac_ctl;

  logic               accept;
  logic               slot_free;
  logic [IW-1:0]      free_idx;
  logic [16:0]        pos_next;
  logic [XW-1:0]      rd_sum;
  logic [XW-1:0]      ld_ext;
  logic               new_voice;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign slot_free = ~&voice_active;
  assign new_voice = accept && (mode == MODE_START) && (length != '0) && slot_free;
  assign pos_next  = vm_rdata.pos + 17'd1;
  assign rd_sum    = XW'(vm_rdata.start_addr) + XW'(vm_rdata.pos);
  assign ld_ext    = XW'(address);

  always_comb begin
    free_idx = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!voice_active[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  assign mac_ctl.clear = accept && (mode == MODE_TICK);
  assign mac_ctl.valid = v2_valid;

  svm_boost u_boost (
    .clk    (clk),
    .volume (system_volume),
    .boost  (boost)
  );

  svm_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctl      (mac_ctl),
    .sample   (sm_rdata),
    .combined (comb2),
    .acc      (acc)
  );

  always_ff @(posedge clk) begin
    if (new_voice) begin
      vmem[free_idx] <= '{start_addr: address, len: length, pos: '0, gain: gain};
    end else if (v1_valid) begin
      vmem[v1_idx] <= '{start_addr: vm_rdata.start_addr, len: vm_rdata.len,
                        pos: pos_next, gain: vm_rdata.gain};
    end
    if (state == S_SCAN) begin
      vm_rdata <= vmem[k];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (mode == MODE_LOAD)) begin
      smem[ld_ext[AW-1:0]] <= sample_value;
    end
    sm_rdata <= smem[rd_sum[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    comb2 <= {16'd0, vm_rdata.gain} * {16'd0, boost};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cnt           <= '0;
      k             <= '0;
      voice_active  <= '0;
      system_volume <= UNITY_Q15;
      any_hold      <= 1'b0;
      v1_valid      <= 1'b0;
      v1_idx        <= '0;
      v2_valid      <= 1'b0;
      done          <= 1'b0;
      mixed_sample  <= '0;
      voices_live   <= 1'b0;
      start_dropped <= 1'b0;
    end else begin
      done     <= 1'b0;
      v1_valid <= 1'b0;
      v2_valid <= v1_valid;
      if (cfg_write) begin
        system_volume <= cfg_data;
      end
      if (v1_valid && !(pos_next < vm_rdata.len)) begin
        voice_active[v1_idx] <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            mixed_sample  <= '0;
            voices_live   <= 1'b0;
            start_dropped <= 1'b0;
            unique case (mode_t'(mode))
              MODE_LOAD: begin
                done <= 1'b1;
              end
              MODE_START: begin
                done          <= 1'b1;
                start_dropped <= (length != '0) && !slot_free;
                if (new_voice) begin
                  voice_active[free_idx] <= 1'b1;
                end
              end
              MODE_TICK: begin
                state    <= S_BOOST;
                cnt      <= '0;
                any_hold <= |voice_active;
              end
              MODE_NONE: begin
                done <= 1'b1;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_BOOST: begin
          cnt <= cnt + 2'd1;
          if (cnt == 2'd1) begin
            state <= S_SCAN;
            cnt   <= '0;
            k     <= '0;
          end
        end
        S_SCAN: begin
          v1_valid <= voice_active[k];
          v1_idx   <= k;
          k        <= k + 1'b1;
          if (k == IW'(VOICES - 1)) begin
            state <= S_DRAIN;
            cnt   <= '0;
          end
        end
        S_DRAIN: begin
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) begin
            state         <= S_IDLE;
            done          <= 1'b1;
            mixed_sample  <= acc;
            voices_live   <= any_hold;
            start_dropped <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while a tick is still running");

  a_drop_clean: assert property (@(posedge clk) disable iff (rst)
    done && start_dropped |-> (mixed_sample == '0) && !voices_live)
    else $error("dropped start carries mix data");

  a_pipe_in_tick: assert property (@(posedge clk) disable iff (rst)
    v1_valid |-> (state == S_SCAN) || (state == S_DRAIN))
    else $error("voice pipeline active outside a tick");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    accept && (mode == MODE_START) && (length != '0) && (&voice_active) |=> start_dropped)
    else $error("start with all slots busy was not flagged");

  a_slot_taken: assert property (@(posedge clk) disable iff (rst)
    new_voice |=> $countones(voice_active) == $past($countones(voice_active)) + 1)
    else $error("start did not claim exactly one slot");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

import svm_pkg::*;

typedef struct {
  logic signed [15:0] mix;
  logic               active;
  logic               dropped;
} mix_result_t;

class mix_predictor;
  localparam int SLOTS = 16;

  logic [15:0] store [0:65535];
  bit          voice_on   [SLOTS];
  logic [15:0] voice_base [SLOTS];
  logic [16:0] voice_len  [SLOTS];
  logic [16:0] voice_pos  [SLOTS];
  logic [15:0] voice_gain [SLOTS];
  logic [15:0] volume;
  mix_result_t pending_mixes [$];
  int          errors;

  function new();
    volume = UNITY_Q15;
    errors = 0;
    for (int i = 0; i < SLOTS; i++) begin
      voice_on[i]   = 1'b0;
      voice_base[i] = '0;
      voice_len[i]  = '0;
      voice_pos[i]  = '0;
      voice_gain[i] = '0;
    end
  endfunction

  function longint unsigned boost_of(logic [15:0] v);
    longint unsigned inv;
    if (v >= UNITY_Q15) return 64'(v);
    inv = 64'(UNITY_Q15 - v);
    return 64'd32768 - ((inv * inv * inv) >> 30);
  endfunction

  function void predict_command(mode_t m, logic [15:0] a, logic [15:0] s,
                                logic [16:0] l, logic [15:0] g);
    mix_result_t     r;
    int              acc;
    longint unsigned level;
    longint unsigned mag;
    longint unsigned part;
    logic [15:0]     word;
    bit              placed;
    r.mix = '0;
    r.active = 1'b0;
    r.dropped = 1'b0;
    case (m)
      MODE_LOAD: begin
        store[a] = s;
      end
      MODE_START: begin
        if (l != 0) begin
          placed = 1'b0;
          for (int i = 0; i < SLOTS && !placed; i++) begin
            if (!voice_on[i]) begin
              voice_on[i]   = 1'b1;
              voice_base[i] = a;
              voice_len[i]  = l;
              voice_pos[i]  = '0;
              voice_gain[i] = g;
              placed = 1'b1;
            end
          end
          r.dropped = !placed;
        end
      end
      MODE_TICK: begin
        acc = 0;
        level = boost_of(volume);
        for (int i = 0; i < SLOTS; i++) begin
          if (voice_on[i]) begin
            r.active = 1'b1;
            word = store[16'(voice_base[i] + voice_pos[i][15:0])];
            mag = word[15] ? 64'd65536 - word : word;
            part = (mag * (voice_gain[i] * level)) >> 30;
            acc += word[15] ? -int'(part) : int'(part);
            if (acc > int'(MIX_MAX)) acc = int'(MIX_MAX);
            else if (acc < int'(MIX_MIN)) acc = int'(MIX_MIN);
            voice_pos[i] = voice_pos[i] + 17'd1;
            if (voice_pos[i] >= voice_len[i]) voice_on[i] = 1'b0;
          end
        end
        r.mix = acc[15:0];
      end
      default: begin
      end
    endcase
    pending_mixes.push_back(r);
  endfunction

  task report(string what);
    errors++;
    if (errors <= 100) $display("ERROR at %0t: %s", $realtime, what);
  endtask

  task check_mix(logic signed [15:0] mix, logic active, logic dropped);
    mix_result_t e;
    if (pending_mixes.size() == 0) begin
      report("result transfer with no command pending");
      return;
    end
    e = pending_mixes.pop_front();
    if (mix !== e.mix)
      report($sformatf("mixed_sample %0d, expected %0d", mix, e.mix));
    if (active !== e.active)
      report($sformatf("voices_live %b, expected %b", active, e.active));
    if (dropped !== e.dropped)
      report($sformatf("start_dropped %b, expected %b", dropped, e.dropped));
  endtask
endclass

module tb_top;
  localparam int          VOICES      = 16;
  localparam int          PHASE_ITEMS = 278;
  localparam int unsigned CYCLE_LIMIT = 600000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         mode = '0;
  logic [15:0]        address = '0;
  logic signed [15:0] sample_value = '0;
  logic [16:0]        length = '0;
  logic [15:0]        gain = '0;
  logic               cfg_write = 1'b0;
  logic [15:0]        cfg_data = '0;
  logic               done;
  logic signed [15:0] mixed_sample;
  logic               voices_live;
  logic               start_dropped;

  int                 idle_pct = 0;
  int                 sent = 0;
  int unsigned        cycles = 0;
  bit                 loaded [0:65535];
  mix_predictor       model = new();

  saturating_voice_mixer dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .mode          (mode),
    .address       (address),
    .sample_value  (sample_value),
    .length        (length),
    .gain          (gain),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .done          (done),
    .mixed_sample  (mixed_sample),
    .voices_live   (voices_live),
    .start_dropped (start_dropped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("saturating_voice_mixer verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done === 1'b1) model.check_mix(mixed_sample, voices_live, start_dropped);
  end

  function automatic logic [15:0] random_sample();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic [15:0] pick_address();
    if ($urandom_range(99) < 80) return 16'($urandom_range(2047));
    return 16'($urandom_range(65535));
  endfunction

  task automatic send_cmd(mode_t m, logic [15:0] a, logic [15:0] s, logic [16:0] l,
                          logic [15:0] g);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start        <= 1'b1;
    mode         <= m;
    address      <= a;
    sample_value <= s;
    length       <= l;
    gain         <= g;
    do @(posedge clk); while (busy !== 1'b0);
    model.predict_command(m, a, s, l, g);
    if (m == MODE_LOAD) loaded[a] = 1'b1;
    sent++;
  endtask

  // Every voice must read a written sample word, so missing words are loaded first.
  task automatic send_tick();
    logic [15:0] a;
    for (int i = 0; i < VOICES; i++) begin
      if (model.voice_on[i]) begin
        a = model.voice_base[i] + model.voice_pos[i][15:0];
        if (!loaded[a])
          send_cmd(MODE_LOAD, a, random_sample(), 17'($urandom_range(65536)),
                   16'($urandom_range(65535)));
      end
    end
    send_cmd(MODE_TICK, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
             17'($urandom_range(65536)), 16'($urandom_range(65535)));
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (model.pending_mixes.size() != 0) @(posedge clk);
    repeat (VOICES + 8) @(posedge clk);
  endtask

  task automatic write_volume(logic [15:0] v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    model.volume = v;
  endtask

  task automatic random_command();
    int          r;
    int          lr;
    logic [16:0] l;
    r = $urandom_range(99);
    if (r < 30) begin
      send_cmd(MODE_LOAD, pick_address(), random_sample(), 17'($urandom_range(65536)),
               16'($urandom_range(65535)));
    end else if (r < 55) begin
      lr = $urandom_range(99);
      if (lr < 3) l = '0;
      else if (lr < 80) l = 17'($urandom_range(16, 1));
      else if (lr < 97) l = 17'($urandom_range(300, 17));
      else l = 17'($urandom_range(65536, 1));
      send_cmd(MODE_START, pick_address(), 16'($urandom_range(65535)), l,
               16'($urandom_range(65535)));
    end else if (r < 95) begin
      send_tick();
    end else begin
      send_cmd(MODE_NONE, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
               17'($urandom_range(65536)), 16'($urandom_range(65535)));
    end
  endtask

  initial begin
    int          phase;
    int          goal;
    logic [15:0] vol;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_cmd(MODE_LOAD, 16'h0000, 16'h8000, 17'd0, 16'd0);
    send_cmd(MODE_LOAD, 16'hFFFF, 16'h7FFF, 17'h10000, 16'hFFFF);
    send_cmd(MODE_LOAD, 16'h5555, 16'h5555, 17'h05555, 16'h5555);
    send_cmd(MODE_LOAD, 16'hAAAA, 16'hAAAA, 17'h0AAAA, 16'hAAAA);
    send_tick();
    send_cmd(MODE_NONE, 16'hFFFF, 16'hFFFF, 17'h10000, 16'hFFFF);
    send_cmd(MODE_START, 16'h0005, 16'h0000, 17'd0, 16'h8000);
    send_cmd(MODE_START, 16'hFFFF, 16'h0000, 17'd3, 16'hFFFF);
    send_cmd(MODE_START, 16'h0000, 16'h0000, 17'h10000, 16'hFFFF);
    send_cmd(MODE_START, 16'h5555, 16'h0000, 17'd1, 16'h0000);
    repeat (3) send_tick();
    repeat (VOICES) send_cmd(MODE_START, 16'hAAAA, 16'h0000, 17'd2,
                             16'($urandom_range(65535)));
    send_tick();

    for (phase = 0; phase < 6; phase++) begin
      settle();
      case (phase)
        0: vol = 16'h0000;
        1: vol = 16'hFFFF;
        2: vol = 16'h0001;
        3: vol = 16'h7FFF;
        4: vol = 16'($urandom_range(32767, 1));
        default: vol = UNITY_Q15;
      endcase
      write_volume(vol);
      idle_pct = (phase < 2) ? 30 : (phase < 4) ? 88 : 0;
      goal = sent + PHASE_ITEMS;
      while (sent < goal) begin
        random_command();
        if ($urandom_range(199) == 0) settle();
      end
    end

    settle();
    if (model.errors == 0) begin
      $display("saturating_voice_mixer verification clean");
    end else begin
      $display("saturating_voice_mixer verification failed");
    end
    $finish;
  end
endmodule
